// ----- hw/rtl/m3inv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int EW         = 32;
  localparam int FB         = 16;
  localparam int TWO_FB     = 2 * FB;
  localparam int PROD_W     = 2 * EW;
  localparam int ADJ_W      = PROD_W + 1;
  localparam int MAG_W      = ADJ_W;
  localparam int DET_W      = 3 * EW + 3;
  localparam int DMAG_W     = DET_W - 1;
  localparam int NUM_W      = MAG_W + TWO_FB;
  localparam int QB         = EW;
  localparam int CMP_W      = DMAG_W + QB;
  localparam int NELEM      = 9;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int FIFO_CW    = 2;

  typedef struct packed {
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a13;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
    logic signed [EW-1:0] a23;
    logic signed [EW-1:0] a31;
    logic signed [EW-1:0] a32;
    logic signed [EW-1:0] a33;
  } in_t;

  typedef struct packed {
    logic signed [EW-1:0] r11;
    logic signed [EW-1:0] r12;
    logic signed [EW-1:0] r13;
    logic signed [EW-1:0] r21;
    logic signed [EW-1:0] r22;
    logic signed [EW-1:0] r23;
    logic signed [EW-1:0] r31;
    logic signed [EW-1:0] r32;
    logic signed [EW-1:0] r33;
    logic                 singular;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic                              sing;
    logic                              dneg;
    logic [DMAG_W-1:0]                 dmag;
    logic [NELEM-1:0]                  nneg;
    logic [NELEM-1:0][MAG_W-1:0]       nmag;
  } job_t;

endpackage

// ----- hw/rtl/m3inv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_front
// Cofactors, adjugate and determinant; classifies singular matrices.
// ----------------------------------------------------------------------------
module m3inv_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire m3inv_pkg::in_t    in_item,
  output logic                   push,
  output m3inv_pkg::job_t        push_job
);

  logic signed [m3inv_pkg::EW-1:0]     m [3][3];
  logic signed [m3inv_pkg::PROD_W-1:0] p_nxt [3][3];
  logic signed [m3inv_pkg::PROD_W-1:0] q_nxt [3][3];
  logic signed [m3inv_pkg::PROD_W-1:0] p_r [3][3];
  logic signed [m3inv_pkg::PROD_W-1:0] q_r [3][3];
  logic signed [m3inv_pkg::EW-1:0]     e1_r [3];
  logic signed [m3inv_pkg::EW-1:0]     e2_r [3];
  logic                                v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [m3inv_pkg::ADJ_W-1:0]  adj_nxt [9];
  logic signed [m3inv_pkg::ADJ_W-1:0]  adj2_r [9];
  logic signed [m3inv_pkg::ADJ_W-1:0]  adj3_r [9];
  logic signed [m3inv_pkg::ADJ_W-1:0]  adj4_r [9];
  logic signed [m3inv_pkg::ADJ_W-1:0]  adj5_r [9];
  logic signed [m3inv_pkg::ADJ_W-1:0]  plo_r [3];
  logic signed [m3inv_pkg::ADJ_W-1:0]  phi_r [3];
  logic signed [m3inv_pkg::DET_W-1:0]  t_r [3];
  logic signed [m3inv_pkg::DET_W-1:0]  det_r;

  always_comb begin
    m[0][0] = in_item.a11; m[0][1] = in_item.a12; m[0][2] = in_item.a13;
    m[1][0] = in_item.a21; m[1][1] = in_item.a22; m[1][2] = in_item.a23;
    m[2][0] = in_item.a31; m[2][1] = in_item.a32; m[2][2] = in_item.a33;
  end

  // 2x2 minor products
  always_comb begin
    int r0, r1, c0, c1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        p_nxt[i][j] = m[r0][c0] * m[r1][c1];
        q_nxt[i][j] = m[r0][c1] * m[r1][c0];
      end
    end
  end

  // signed cofactors, transposed into the adjugate
  always_comb begin
    logic signed [m3inv_pkg::ADJ_W-1:0] mn;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mn = m3inv_pkg::ADJ_W'(p_r[i][j]) - m3inv_pkg::ADJ_W'(q_r[i][j]);
        adj_nxt[j*3+i] = ((i + j) % 2 == 1) ? -mn : mn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_r[i][j] <= p_nxt[i][j];
        q_r[i][j] <= q_nxt[i][j];
      end
      e1_r[i] <= m[0][i];
      e2_r[i] <= e1_r[i];
    end
    for (int k = 0; k < 9; k++) begin
      adj2_r[k] <= adj_nxt[k];
      adj3_r[k] <= adj2_r[k];
      adj4_r[k] <= adj3_r[k];
      adj5_r[k] <= adj4_r[k];
    end
    // determinant by first-row expansion, cofactor split in two halves
    for (int j = 0; j < 3; j++) begin
      plo_r[j] <= e2_r[j] * $signed({1'b0, adj2_r[3*j][m3inv_pkg::EW-1:0]});
      phi_r[j] <= e2_r[j] * $signed(adj2_r[3*j][m3inv_pkg::ADJ_W-1:m3inv_pkg::EW]);
      t_r[j]   <= (m3inv_pkg::DET_W'(phi_r[j]) <<< m3inv_pkg::EW)
                  + m3inv_pkg::DET_W'(plo_r[j]);
    end
    det_r <= t_r[0] + t_r[1] + t_r[2];
  end

  always_comb begin
    logic signed [m3inv_pkg::DET_W-1:0] dabs;
    logic signed [m3inv_pkg::ADJ_W-1:0] aabs;
    push           = v5_r;
    push_job.sing  = (det_r == '0);
    push_job.dneg  = det_r[m3inv_pkg::DET_W-1];
    dabs           = det_r[m3inv_pkg::DET_W-1] ? -det_r : det_r;
    push_job.dmag  = dabs[m3inv_pkg::DMAG_W-1:0];
    for (int k = 0; k < 9; k++) begin
      push_job.nneg[k] = adj5_r[k][m3inv_pkg::ADJ_W-1];
      aabs             = adj5_r[k][m3inv_pkg::ADJ_W-1] ? -adj5_r[k] : adj5_r[k];
      push_job.nmag[k] = aabs;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module m3inv_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire m3inv_pkg::job_t push_job,
  input  wire logic            pop,
  output logic                 not_empty,
  output logic                 full,
  output m3inv_pkg::job_t      head
);

  m3inv_pkg::job_t                  mem_r [m3inv_pkg::FIFO_DEPTH];
  logic [m3inv_pkg::FIFO_AW-1:0]    wp_r, rp_r;
  logic [m3inv_pkg::FIFO_CW-1:0]    cnt_r;
  logic                             do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == m3inv_pkg::FIFO_CW'(m3inv_pkg::FIFO_DEPTH));
  assign head      = mem_r[rp_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + m3inv_pkg::FIFO_CW'(push) - m3inv_pkg::FIFO_CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_div_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_div_lane
// Pipelined restoring divider for one adjugate entry, with saturation.
// ----------------------------------------------------------------------------
module m3inv_div_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [m3inv_pkg::MAG_W-1:0]   num_mag,
  input  wire logic                          num_neg,
  input  wire logic [m3inv_pkg::DMAG_W-1:0]  den_mag,
  input  wire logic                          den_neg,
  input  wire logic                          sing,
  output logic                               out_valid,
  output logic [m3inv_pkg::EW-1:0]           res,
  output logic                               ovf
);

  localparam int S = m3inv_pkg::QB;

  logic                              vld_r  [S+1];
  logic [m3inv_pkg::NUM_W-1:0]       rem_r  [S+1];
  logic [m3inv_pkg::QB-1:0]          q_r    [S+1];
  logic [m3inv_pkg::DMAG_W-1:0]      den_r  [S+1];
  logic                              neg_r  [S+1];
  logic                              big_r  [S+1];
  logic                              sing_r [S+1];
  logic [m3inv_pkg::NUM_W-1:0]       rem_nxt [S+1];
  logic [m3inv_pkg::QB-1:0]          q_nxt   [S+1];
  logic [m3inv_pkg::CMP_W-1:0]       trial   [S+1];
  logic [m3inv_pkg::CMP_W-1:0]       num_ext;
  logic [m3inv_pkg::CMP_W-1:0]       lim_ext;
  logic [m3inv_pkg::QB-1:0]          qf;
  logic                              out_valid_r, ovf_r;
  logic [m3inv_pkg::EW-1:0]          res_r;

  assign num_ext = m3inv_pkg::CMP_W'({num_mag, {m3inv_pkg::TWO_FB{1'b0}}});
  assign lim_ext = m3inv_pkg::CMP_W'(den_mag) << m3inv_pkg::QB;

  always_comb begin
    logic ge;
    rem_nxt[0] = '0;
    q_nxt[0]   = '0;
    trial[0]   = '0;
    for (int s = 1; s <= S; s++) begin
      trial[s] = m3inv_pkg::CMP_W'(den_r[s-1]) << (S - s);
      ge       = (m3inv_pkg::CMP_W'(rem_r[s-1]) >= trial[s]);
      rem_nxt[s] = ge ? m3inv_pkg::NUM_W'(m3inv_pkg::CMP_W'(rem_r[s-1]) - trial[s])
                      : rem_r[s-1];
      q_nxt[s]   = q_r[s-1] | (m3inv_pkg::QB'(ge) << (S - s));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= S; s++) vld_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= S; s++) vld_r[s] <= vld_r[s-1];
      out_valid_r <= vld_r[S];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= m3inv_pkg::NUM_W'({num_mag, {m3inv_pkg::TWO_FB{1'b0}}});
    q_r[0]    <= '0;
    den_r[0]  <= den_mag;
    neg_r[0]  <= num_neg ^ den_neg;
    big_r[0]  <= (num_ext >= lim_ext);
    sing_r[0] <= sing;
    for (int s = 1; s <= S; s++) begin
      rem_r[s]  <= rem_nxt[s];
      q_r[s]    <= q_nxt[s];
      den_r[s]  <= den_r[s-1];
      neg_r[s]  <= neg_r[s-1];
      big_r[s]  <= big_r[s-1];
      sing_r[s] <= sing_r[s-1];
    end
  end

  assign qf = q_r[S];

  // saturate to the signed element range; a singular job gives zero
  always_ff @(posedge clk) begin
    if (sing_r[S]) begin
      res_r <= '0;
      ovf_r <= 1'b0;
    end else if (!neg_r[S]) begin
      if (big_r[S] || qf[m3inv_pkg::QB-1]) begin
        res_r <= {1'b0, {(m3inv_pkg::EW-1){1'b1}}};
        ovf_r <= 1'b1;
      end else begin
        res_r <= qf;
        ovf_r <= 1'b0;
      end
    end else begin
      if (big_r[S] || (qf[m3inv_pkg::QB-1] && (qf[m3inv_pkg::QB-2:0] != '0))) begin
        res_r <= {1'b1, {(m3inv_pkg::EW-1){1'b0}}};
        ovf_r <= 1'b1;
      end else begin
        res_r <= ~qf + 1'b1;
        ovf_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign ovf       = ovf_r;

endmodule
`default_nettype wire

// ----- hw/rtl/m3inv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_back
// Nine divider lanes; assembles the inverse and the status flags.
// ----------------------------------------------------------------------------
module m3inv_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire m3inv_pkg::job_t job,
  output logic                 pop,
  output logic                 out_valid,
  output m3inv_pkg::out_t      out_item
);

  logic [m3inv_pkg::NELEM-1:0]        lane_valid;
  logic [m3inv_pkg::NELEM-1:0]        lane_ovf;
  logic [m3inv_pkg::EW-1:0]           lane_res [m3inv_pkg::NELEM];
  logic                               sing_d_r [m3inv_pkg::QB+2];

  assign pop = job_valid;

  for (genvar k = 0; k < m3inv_pkg::NELEM; k++) begin : g_lane
    m3inv_div_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (job_valid),
      .num_mag   (job.nmag[k]),
      .num_neg   (job.nneg[k]),
      .den_mag   (job.dmag),
      .den_neg   (job.dneg),
      .sing      (job.sing),
      .out_valid (lane_valid[k]),
      .res       (lane_res[k]),
      .ovf       (lane_ovf[k])
    );
  end

  always_ff @(posedge clk) begin
    sing_d_r[0] <= job.sing;
    for (int s = 1; s < m3inv_pkg::QB + 2; s++) sing_d_r[s] <= sing_d_r[s-1];
  end

  assign out_valid         = lane_valid[0];
  assign out_item.r11      = lane_res[0];
  assign out_item.r12      = lane_res[1];
  assign out_item.r13      = lane_res[2];
  assign out_item.r21      = lane_res[3];
  assign out_item.r22      = lane_res[4];
  assign out_item.r23      = lane_res[5];
  assign out_item.r31      = lane_res[6];
  assign out_item.r32      = lane_res[7];
  assign out_item.r33      = lane_res[8];
  assign out_item.singular = sing_d_r[m3inv_pkg::QB+1];
  assign out_item.overflow = |lane_ovf;

endmodule
`default_nettype wire

// ----- hw/rtl/matrix3_inverse_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 signed Q16.16 matrix inverse by adjugate and determinant.
// ----------------------------------------------------------------------------
// throughput: one matrix per cycle while busy is low, set by the pipelined divider lanes
// busy only rises if the job queue fills; results are never held off
// reset clears all valid bits; in-flight items are dropped
module matrix3_inverse_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire m3inv_pkg::in_t   in_item,
  output logic                  out_valid,
  output m3inv_pkg::out_t       out_item
);

  logic            push, pop, not_empty, full;
  m3inv_pkg::job_t push_job, head;

  assign busy = full;

  m3inv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .push     (push),
    .push_job (push_job)
  );

  m3inv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (not_empty),
    .full      (full),
    .head      (head)
  );

  m3inv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (not_empty),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
